// ----- hdl/rgb_to_hue_degrees_defines.svh -----
// Assertion macros for the files that check their own logic.
`ifndef RGB_TO_HUE_DEGREES_DEFINES_SVH
`define RGB_TO_HUE_DEGREES_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RTH_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hue_degrees: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RTH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hue_degrees: next-cycle check failed");

`endif

// ----- hdl/rth_pkg.sv -----
package rth_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int QUO_BITS     = 6;
  localparam int NUM_W        = CHANNEL_BITS + QUO_BITS;
  localparam int HUE_BITS     = 9;
  localparam int HUE_SECTOR   = 60;

  localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = HUE_BITS'(120);
  localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE  = HUE_BITS'(240);
  localparam logic [HUE_BITS-1:0] HUE_FULL_TURN  = HUE_BITS'(360);

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } rth_sel_t;

  typedef struct packed {
    logic     valid;
    logic     achro;
    logic     neg;
    rth_sel_t sel;
  } rth_side_t;

endpackage

// ----- hdl/rth_if.sv -----
interface rth_in_if import rth_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_out_if import rth_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HUE_BITS-1:0] hue;
  logic                achromatic;

  modport source (output valid, output hue, output achromatic, input ready);
  modport sink (input valid, input hue, input achromatic, output ready);
endinterface

// ----- hdl/rth_div.sv -----
module rth_div import rth_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en_i,
  input  rth_side_t               side_i,
  input  logic [NUM_W-1:0]        num_i,
  input  logic [CHANNEL_BITS-1:0] span_i,
  output rth_side_t               side_o,
  output logic [QUO_BITS-1:0]     q_o
);

  // One quotient bit per stage, most significant first. The quotient never exceeds 60.
  rth_side_t               side_r [QUO_BITS];
  logic [QUO_BITS-1:0]     q_r    [QUO_BITS];
  logic [NUM_W-1:0]        rem_r  [QUO_BITS-1];
  logic [CHANNEL_BITS-1:0] span_r [QUO_BITS-1];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
    localparam int K = QUO_BITS - 1 - i;

    rth_side_t               side_in;
    logic [NUM_W-1:0]        rem_in;
    logic [CHANNEL_BITS-1:0] span_in;
    logic [QUO_BITS-1:0]     q_in;
    logic [NUM_W-1:0]        span_sh;
    logic [NUM_W:0]          trial;
    logic [QUO_BITS-1:0]     q_nxt;

    if (i == 0) begin : g_first
      assign side_in = side_i;
      assign rem_in  = num_i;
      assign span_in = span_i;
      assign q_in    = '0;
    end else begin : g_rest
      assign side_in = side_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign span_in = span_r[i-1];
      assign q_in    = q_r[i-1];
    end

    always_comb begin
      span_sh  = NUM_W'(span_in) << K;
      trial    = {1'b0, rem_in} - {1'b0, span_sh};
      q_nxt    = q_in;
      q_nxt[K] = ~trial[NUM_W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i] <= '0;
      end else if (en_i) begin
        side_r[i] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        q_r[i] <= q_nxt;
      end
    end

    if (i < QUO_BITS - 1) begin : g_pass
      logic [NUM_W-1:0] rem_nxt;

      assign rem_nxt = trial[NUM_W] ? rem_in : trial[NUM_W-1:0];

      always_ff @(posedge clk) begin
        if (en_i) begin
          rem_r[i]  <= rem_nxt;
          span_r[i] <= span_in;
        end
      end
    end
  end

  assign side_o = side_r[QUO_BITS-1];
  assign q_o    = q_r[QUO_BITS-1];

endmodule

// ----- hdl/rgb_to_hue_degrees.sv -----
// RGB to HSV hue converter.
// The in_ch channel carries one red, green and blue sample per transaction; the
// out_ch channel returns the hue in whole degrees (0 to 359) and an achromatic
// flag, which is set with a hue of 0 when all three samples are equal.
// Both channels use a valid/ready handshake and one transaction moves one item.
// The datapath is a ten-stage pipeline: channel compare, span and magnitude,
// scaling by 60, six restoring divider stages of one quotient bit each, and the
// output register. A new input is taken every cycle while the receiver keeps
// ready high, so the throughput is one item per clock.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and in_ch.ready drops in the same cycle; nothing is lost or repeated.
// Reset is synchronous and active low; it clears all valid bits, so the
// pipeline comes up empty and in_ch.ready is high in the first cycle after it.
`include "rgb_to_hue_degrees_defines.svh"

module rgb_to_hue_degrees import rth_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  rth_in_if.sink  in_ch,
  rth_out_if.source out_ch
);

  logic adv;

  // Stage 1: largest and smallest channel and the signed difference.
  logic                    v1_r, v1_nxt;
  rth_sel_t                sel1_r, sel1_nxt;
  logic [CHANNEL_BITS-1:0] hi1_r, hi1_nxt;
  logic [CHANNEL_BITS-1:0] lo1_r, lo1_nxt;
  logic [CHANNEL_BITS:0]   diff1_r, diff1_nxt;

  // Stage 2: span, grey detect and difference magnitude.
  rth_side_t               side2_r, side2_nxt;
  logic [CHANNEL_BITS-1:0] span2_r, span2_nxt;
  logic [CHANNEL_BITS-1:0] mag2_r, mag2_nxt;

  // Stage 3: numerator scaled by 60.
  rth_side_t               side3_r;
  logic [CHANNEL_BITS-1:0] span3_r;
  logic [NUM_W-1:0]        num3_r, num3_nxt;

  rth_side_t           div_side;
  logic [QUO_BITS-1:0] div_q;

  // Output register.
  logic                out_valid_r;
  logic [HUE_BITS-1:0] hue_r, hue_nxt;
  logic                achro_r, achro_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign v1_nxt      = in_ch.valid;

  always_comb begin
    logic [CHANNEL_BITS:0]   d_gb;
    logic [CHANNEL_BITS:0]   d_br;
    logic [CHANNEL_BITS:0]   d_rg;
    logic [CHANNEL_BITS-1:0] lo_rg;
    d_gb = {1'b0, in_ch.green} - {1'b0, in_ch.blue};
    d_br = {1'b0, in_ch.blue} - {1'b0, in_ch.red};
    d_rg = {1'b0, in_ch.red} - {1'b0, in_ch.green};
    if (in_ch.red > in_ch.green) begin
      hi1_nxt  = in_ch.red;
      sel1_nxt = SEL_RED;
    end else begin
      hi1_nxt  = in_ch.green;
      sel1_nxt = SEL_GREEN;
    end
    if (hi1_nxt < in_ch.blue) begin
      hi1_nxt  = in_ch.blue;
      sel1_nxt = SEL_BLUE;
    end
    lo_rg   = (in_ch.red < in_ch.green) ? in_ch.red : in_ch.green;
    lo1_nxt = (lo_rg > in_ch.blue) ? in_ch.blue : lo_rg;
    case (sel1_nxt)
      SEL_RED:   diff1_nxt = d_gb;
      SEL_GREEN: diff1_nxt = d_br;
      SEL_BLUE:  diff1_nxt = d_rg;
      default:   diff1_nxt = '0;
    endcase
  end

  always_comb begin
    logic [CHANNEL_BITS:0] mag_full;
    side2_nxt.valid = v1_r;
    side2_nxt.sel   = sel1_r;
    side2_nxt.neg   = diff1_r[CHANNEL_BITS];
    side2_nxt.achro = (hi1_r == lo1_r);
    span2_nxt       = hi1_r - lo1_r;
    mag_full        = diff1_r[CHANNEL_BITS] ? (~diff1_r + 1'b1) : diff1_r;
    mag2_nxt        = mag_full[CHANNEL_BITS-1:0];
  end

  assign num3_nxt = NUM_W'(mag2_r) * NUM_W'(HUE_SECTOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      side2_r <= '0;
      side3_r <= '0;
    end else if (adv) begin
      v1_r    <= v1_nxt;
      side2_r <= side2_nxt;
      side3_r <= side2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel1_r  <= sel1_nxt;
      hi1_r   <= hi1_nxt;
      lo1_r   <= lo1_nxt;
      diff1_r <= diff1_nxt;
      span2_r <= span2_nxt;
      mag2_r  <= mag2_nxt;
      span3_r <= span2_r;
      num3_r  <= num3_nxt;
    end
  end

  rth_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en_i   (adv),
    .side_i (side3_r),
    .num_i  (num3_r),
    .span_i (span3_r),
    .side_o (div_side),
    .q_o    (div_q)
  );

  always_comb begin
    logic [HUE_BITS-1:0] base;
    logic [HUE_BITS-1:0] q_ext;
    q_ext = HUE_BITS'(div_q);
    case (div_side.sel)
      SEL_RED:   base = (div_side.neg && (div_q != '0)) ? HUE_FULL_TURN : '0;
      SEL_GREEN: base = HUE_GREEN_BASE;
      SEL_BLUE:  base = HUE_BLUE_BASE;
      default:   base = '0;
    endcase
    if (div_side.achro) begin
      hue_nxt = '0;
    end else if (div_side.neg) begin
      hue_nxt = base - q_ext;
    end else begin
      hue_nxt = base + q_ext;
    end
    achro_nxt = div_side.achro;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r   <= hue_nxt;
      achro_r <= achro_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hue        = hue_r;
  assign out_ch.achromatic = achro_r;

  `RTH_ASSERT_IMPL(a_grey_hue_zero, out_valid_r && achro_r, hue_r == '0)
  `RTH_ASSERT_IMPL(a_hue_range, out_valid_r, hue_r < HUE_FULL_TURN)
  `RTH_ASSERT_IMPL(a_stall_blocks_input, out_valid_r && !out_ch.ready, !in_ch.ready)
  `RTH_ASSERT_NEXT(a_div_to_out, div_side.valid && adv, out_valid_r)

endmodule

// ----- bench/tb_rgb_to_hue_degrees.sv -----
`timescale 1ns / 100ps

module tb_rgb_to_hue_degrees;
  import rth_pkg::*;

  typedef struct {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    int unsigned             gap;
  } pixel_t;

  typedef struct {
    logic [HUE_BITS-1:0] hue;
    logic                achromatic;
  } hue_t;

  localparam int unsigned MAX_IDLE = 11;
  localparam int unsigned RANDOM_PIXELS = 1750;
  localparam int unsigned HOLD_AFTER = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;

  rth_in_if  in_ch ();
  rth_out_if out_ch ();

  rgb_to_hue_degrees dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pixel_t      pending_px_q[$];
  hue_t        hue_expect_q[$];
  pixel_t      cur_px;
  int unsigned mismatch_count = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned send_wait = 0;
  bit          gap_loaded = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned hold_cnt = 0;
  int unsigned in_seen = 0;
  bit          hold_done = 1'b0;

  function automatic hue_t predict_hue(pixel_t px);
    longint   r;
    longint   g;
    longint   b;
    longint   hi;
    longint   lo;
    longint   span;
    longint   h;
    rth_sel_t sel;
    hue_t     res;
    r = longint'(px.red);
    g = longint'(px.green);
    b = longint'(px.blue);
    if (r > g) begin
      hi = r;
      sel = SEL_RED;
    end else begin
      hi = g;
      sel = SEL_GREEN;
    end
    if (hi < b) begin
      hi = b;
      sel = SEL_BLUE;
    end
    lo = (r < g) ? r : g;
    if (lo > b) begin
      lo = b;
    end
    span = hi - lo;
    if (span == 0) begin
      res.hue = '0;
      res.achromatic = 1'b1;
      return res;
    end
    case (sel)
      SEL_RED: begin
        h = (HUE_SECTOR * (g - b)) / span;
      end
      SEL_GREEN: begin
        h = longint'(HUE_GREEN_BASE) + (HUE_SECTOR * (b - r)) / span;
      end
      default: begin
        h = longint'(HUE_BLUE_BASE) + (HUE_SECTOR * (r - g)) / span;
      end
    endcase
    if (h < 0) begin
      h = h + longint'(HUE_FULL_TURN);
    end
    res.hue = h[HUE_BITS-1:0];
    res.achromatic = 1'b0;
    return res;
  endfunction

  function automatic void queue_pixel(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                                      logic [CHANNEL_BITS-1:0] b);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
    pending_px_q.push_back(px);
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] draw_channel(int unsigned style,
                                                           logic [CHANNEL_BITS-1:0] anchor);
    case (style)
      0: return CHANNEL_BITS'($urandom_range(0, 15));
      1: return anchor + CHANNEL_BITS'($urandom_range(0, 2)) - CHANNEL_BITS'(1);
      2: return CHANNEL_BITS'(1) << $urandom_range(0, CHANNEL_BITS - 1);
      3: return ~CHANNEL_BITS'($urandom_range(0, 15));
      default: return CHANNEL_BITS'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait = 0;
      gap_loaded = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        hue_expect_q.push_back(predict_hue(cur_px));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (!gap_loaded && pending_px_q.size() > 0) begin
          send_wait = pending_px_q[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_loaded && send_wait == 0) begin
          cur_px = pending_px_q.pop_front();
          gap_loaded = 1'b0;
          in_ch.red <= cur_px.red;
          in_ch.green <= cur_px.green;
          in_ch.blue <= cur_px.blue;
          in_ch.valid <= 1'b1;
        end else begin
          if (send_wait > 0) begin
            send_wait--;
          end
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // The receiver stops for one long stretch so that the pipeline holds and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      in_seen <= 0;
      hold_done <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_seen <= in_seen + 1;
      end
      if (!hold_done && in_seen == HOLD_AFTER) begin
        hold_cnt <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  always @(posedge clk) begin
    hue_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hue_expect_q.size() == 0) begin
          note_mismatch($sformatf("result with none expected: hue %0d achromatic %0b",
                                  out_ch.hue, out_ch.achromatic));
        end else begin
          want = hue_expect_q.pop_front();
          if (out_ch.hue !== want.hue) begin
            note_mismatch($sformatf("hue %0d, expected %0d", out_ch.hue, want.hue));
          end
          if (out_ch.achromatic !== want.achromatic) begin
            note_mismatch($sformatf("achromatic %0b, expected %0b",
                                    out_ch.achromatic, want.achromatic));
          end
        end
        if ($urandom_range(0, 99) == 0) begin
          rx_calm = !rx_calm;
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ch.ready <= (hold_cnt == 0) && (rx_wait == 0);
    end
  end

  initial begin
    int unsigned             style;
    logic [CHANNEL_BITS-1:0] anchor;
    int unsigned             settle;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    out_ch.ready = 1'b0;

    queue_pixel(16'h0000, 16'h0000, 16'h0000);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_pixel(16'hFFFF, 16'h0000, 16'h0000);
    queue_pixel(16'h0000, 16'hFFFF, 16'h0000);
    queue_pixel(16'h0000, 16'h0000, 16'hFFFF);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
    queue_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
    queue_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    queue_pixel(16'hFFFF, 16'h0000, 16'h0001);
    queue_pixel(16'hFFFF, 16'h0000, 16'hFFFE);
    queue_pixel(16'h0000, 16'h0001, 16'hFFFF);
    queue_pixel(16'h0001, 16'hFFFF, 16'h0000);
    queue_pixel(16'h0001, 16'h0000, 16'h0000);
    queue_pixel(16'h0001, 16'h0001, 16'h0000);
    queue_pixel(16'h0001, 16'h0000, 16'h0001);
    queue_pixel(16'h0000, 16'h0001, 16'h0001);
    queue_pixel(16'h8000, 16'h8000, 16'h8000);
    queue_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    queue_pixel(16'h5555, 16'hAAAA, 16'h5555);
    queue_pixel(16'hFFFE, 16'hFFFF, 16'hFFFD);
    queue_pixel(16'h7FFF, 16'h8000, 16'h0000);

    for (int unsigned i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 100 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      style = $urandom_range(0, 9);
      anchor = CHANNEL_BITS'($urandom);
      queue_pixel(draw_channel(style, anchor), draw_channel(style, anchor),
                  draw_channel(style, anchor));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    settle = 0;
    while (pending_px_q.size() > 0 || in_ch.valid || hue_expect_q.size() > 0) begin
      @(negedge clk);
    end
    while (settle < DRAIN_CYCLES) begin
      @(negedge clk);
      settle++;
    end

    if (mismatch_count == 0 && hue_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rth_pkg.sv
hdl/rth_if.sv
hdl/rth_div.sv
hdl/rgb_to_hue_degrees.sv
bench/tb_rgb_to_hue_degrees.sv
